[sv/spq_pkg.sv]
// Package: shared types and constants for the signal pending queue.
`timescale 1ns / 1ps
package spq_pkg;
  localparam int THREADS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int SHARED_SIGNALS = 32;
  localparam int SIG_W = 7;
  localparam int THREAD_W = 4;

  typedef enum logic [2:0] {
    ST_QUEUED  = 3'd0,
    ST_ALREADY = 3'd1,
    ST_DROPPED = 3'd2,
    ST_FOUND   = 3'd3,
    ST_NONE    = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SH_RD, S_SH_WAIT, S_SH_CHK, S_RT_RD, S_RT_WAIT, S_RT_CHK,
    S_MV_RD, S_MV_WAIT, S_MV_WR, S_DONE
  } fsm_t;
endpackage

[sv/spq_mem.sv]
// Memory: one write port, one registered read port.
`timescale 1ns / 1ps
module spq_mem #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 71
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[sv/signal_pending_queue_core.sv]
// Top level: pending signal store with a sequenced scan over shared slots and queues.
//   channel | handshake          | fields
//   request | start / busy       | kind thread sig_number info_code info_value hold_mask
//   result  | done (one strobe)  | status out_sig_number out_code out_value
// Enqueue: the read, wait, check and done states follow the accepting edge; done is registered in the done state.
// Fetch: each shared slot scanned (32 slots) passes read, wait and check states, then
// each queue entry scanned passes the same states and each entry shifted to close the
// gap passes read, wait and write; the wait states cover the registered read port.
// Reset clears pending bits and queue counts at once; no clearing pass.
// The receiver cannot stall: done is high for one cycle, busy is already low in it.
`timescale 1ns / 1ps
module signal_pending_queue_core
  import spq_pkg::*;
#(
  parameter int THREADS = THREADS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 kind,
  input  logic [3:0]           thread,
  input  logic [6:0]           sig_number,
  input  logic signed [31:0]   info_code,
  input  logic [31:0]          info_value,
  input  logic [63:0]          hold_mask,
  output logic                 done,
  output logic [2:0]           status,
  output logic [6:0]           out_sig_number,
  output logic signed [31:0]   out_code,
  output logic [31:0]          out_value
);
  localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int RTD = (1 << TW) * (1 << QW);
  localparam int RW = TW + QW;

  fsm_t state, state_next;
  logic [SHARED_SIGNALS-1:0] pend;
  logic [CW-1:0] cnt [THREADS];

  logic        r_kind;
  logic [3:0]  r_thr;
  logic [6:0]  r_sig;
  logic [31:0] r_code, r_val;
  logic [63:0] r_mask;
  logic [4:0]  idx;
  logic [CW-1:0] k;

  logic        sh_we;
  logic [4:0]  sh_ra;
  logic [63:0] sh_rd;
  logic        rt_we;
  logic [RW-1:0] rt_wa, rt_ra;
  logic [70:0] rt_wd, rt_rd;

  logic thr_ok;
  logic [CW-1:0] tcnt;
  logic [TW-1:0] tix;
  assign tix = r_thr[TW-1:0];
  assign thr_ok = ({28'd0, r_thr} < 32'(THREADS));
  assign tcnt = thr_ok ? cnt[tix] : '0;

  spq_mem #(.DEPTH(SHARED_SIGNALS), .WIDTH(64)) u_sh (
    .clk(clk), .we(sh_we), .waddr(r_sig[4:0] - 5'd1), .wdata({r_code, r_val}),
    .raddr(sh_ra), .rdata(sh_rd));

  spq_mem #(.DEPTH(RTD), .WIDTH(71)) u_rt (
    .clk(clk), .we(rt_we), .waddr(rt_wa), .wdata(rt_wd), .raddr(rt_ra), .rdata(rt_rd));

  logic [6:0] rt_s;
  logic       rt_blk;
  assign rt_s = rt_rd[70:64];
  assign rt_blk = r_mask[6'(rt_s - 7'd1)];

  logic [6:0] shs;
  assign shs = {2'b0, idx} + 7'd1;

  always_comb begin
    state_next = state;
    sh_we = 1'b0;
    sh_ra = idx;
    rt_we = 1'b0;
    rt_wa = {tix, QW'(k)};
    rt_wd = {r_sig, r_code, r_val};
    rt_ra = {tix, QW'(k)};
    case (state)
      S_IDLE:    if (start) state_next = S_SH_RD;
      S_SH_RD:   state_next = S_SH_WAIT;
      S_SH_WAIT: state_next = S_SH_CHK;
      S_SH_CHK: begin
        if (r_kind == 1'b0) begin
          if (r_sig == 7'd0 || r_sig > 7'd64) state_next = S_DONE;
          else if (r_sig <= 7'd32) begin
            if (!pend[r_sig[4:0] - 5'd1]) sh_we = 1'b1;
            state_next = S_DONE;
          end else begin
            if (thr_ok && tcnt < CW'(QUEUE_DEPTH)) begin
              rt_we = 1'b1;
              rt_wa = {tix, QW'(tcnt)};
            end
            state_next = S_DONE;
          end
        end else if (pend[idx] && !r_mask[{1'b0, idx}]) state_next = S_DONE;
        else if (idx == 5'd31) state_next = S_RT_RD;
        else state_next = S_SH_RD;
      end
      S_RT_RD:   state_next = (k < tcnt) ? S_RT_WAIT : S_DONE;
      S_RT_WAIT: state_next = S_RT_CHK;
      S_RT_CHK:  state_next = rt_blk ? S_RT_RD : S_MV_RD;
      S_MV_RD: begin
        // count already dropped by one here
        rt_ra = {tix, QW'(k + CW'(1))};
        state_next = (k < tcnt) ? S_MV_WAIT : S_DONE;
      end
      S_MV_WAIT: begin
        rt_ra = {tix, QW'(k + CW'(1))};
        state_next = S_MV_WR;
      end
      S_MV_WR: begin
        rt_we = 1'b1;
        rt_wd = rt_rd;
        state_next = S_MV_RD;
      end
      S_DONE:    state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend <= '0;
      for (int t = 0; t < THREADS; t++) cnt[t] <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= 1'b0;
      case (state)
        S_IDLE: if (start) begin
          r_kind <= kind; r_thr <= thread; r_sig <= sig_number;
          r_code <= info_code; r_val <= info_value; r_mask <= hold_mask;
          idx <= 5'd0; k <= '0;
          out_sig_number <= '0; out_code <= '0; out_value <= '0;
          status <= ST_NONE;
        end
        S_SH_CHK: begin
          if (r_kind == 1'b0) begin
            if (r_sig == 7'd0 || r_sig > 7'd64) status <= ST_DROPPED;
            else if (r_sig <= 7'd32) begin
              if (pend[r_sig[4:0] - 5'd1]) status <= ST_ALREADY;
              else begin
                status <= ST_QUEUED;
                pend[r_sig[4:0] - 5'd1] <= 1'b1;
              end
            end else if (thr_ok && tcnt < CW'(QUEUE_DEPTH)) begin
              status <= ST_QUEUED;
              cnt[tix] <= tcnt + CW'(1);
            end else status <= ST_DROPPED;
          end else if (pend[idx] && !r_mask[{1'b0, idx}]) begin
            pend[idx] <= 1'b0;
            status <= ST_FOUND;
            out_sig_number <= shs;
            out_code <= sh_rd[63:32];
            out_value <= sh_rd[31:0];
          end else idx <= idx + 5'd1;
        end
        S_RT_CHK: begin
          if (rt_blk) k <= k + CW'(1);
          else begin
            status <= ST_FOUND;
            out_sig_number <= rt_s;
            out_code <= rt_rd[63:32];
            out_value <= rt_rd[31:0];
            cnt[tix] <= tcnt - CW'(1);
          end
        end
        S_MV_WR: k <= k + CW'(1);
        S_DONE: done <= 1'b1;
        default: ;
      endcase
    end
  end

  assign busy = (state != S_IDLE);
endmodule

[tb/sv/tb.sv]
// Testbench for signal_pending_queue_core: directed table, then random checked requests.
`timescale 1ns / 1ps
module tb;
  import spq_pkg::*;

  localparam int NTHR = 16;
  localparam int QDEPTH = 16;
  localparam int RAND_REQS = 450;
  localparam int CYCLE_LIMIT = 900000;
  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_FETCH = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [3:0]  thread;
    logic [6:0]  sig_number;
    logic [31:0] info_code;
    logic [31:0] info_value;
    logic [63:0] hold_mask;
  } sig_req_t;

  typedef struct packed {
    status_t     status;
    logic [6:0]  sig;
    logic [31:0] code;
    logic [31:0] value;
  } sig_res_t;

  typedef struct {
    sig_req_t req;
    bit       typed;
    sig_res_t res;
  } table_row_t;

  logic clk, rst, start, kind;
  logic [3:0] thread;
  logic [6:0] sig_number;
  logic signed [31:0] info_code;
  logic [31:0] info_value;
  logic [63:0] hold_mask;
  logic busy, done;
  logic [2:0] status;
  logic [6:0] out_sig_number;
  logic signed [31:0] out_code;
  logic [31:0] out_value;

  signal_pending_queue_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind), .thread(thread),
    .sig_number(sig_number), .info_code(info_code), .info_value(info_value),
    .hold_mask(hold_mask), .done(done), .status(status),
    .out_sig_number(out_sig_number), .out_code(out_code), .out_value(out_value)
  );

  // predictor state
  bit          sh_pend[32];
  logic [31:0] sh_code[32];
  logic [31:0] sh_value[32];
  logic [6:0]  rt_sig[NTHR][$];
  logic [31:0] rt_code[NTHR][$];
  logic [31:0] rt_value[NTHR][$];

  sig_res_t pending_results[$];
  int fails = 0;
  int cycles = 0;
  bit quiet = 0;

  function automatic sig_res_t mk(status_t s, logic [6:0] n, logic [31:0] c, logic [31:0] v);
    sig_res_t r;
    r.status = s; r.sig = n; r.code = c; r.value = v;
    return r;
  endfunction

  function automatic sig_res_t predict_signal(sig_req_t q);
    int t;
    logic [6:0] n;
    t = q.thread;
    if (q.kind == KIND_ENQ) begin
      n = q.sig_number;
      if (n == 0 || n > 64) return mk(ST_DROPPED, 0, 0, 0);
      if (n <= 32) begin
        if (sh_pend[n-1]) return mk(ST_ALREADY, 0, 0, 0);
        sh_pend[n-1] = 1; sh_code[n-1] = q.info_code; sh_value[n-1] = q.info_value;
        return mk(ST_QUEUED, 0, 0, 0);
      end
      if (t >= NTHR || rt_sig[t].size() >= QDEPTH) return mk(ST_DROPPED, 0, 0, 0);
      rt_sig[t].push_back(n); rt_code[t].push_back(q.info_code);
      rt_value[t].push_back(q.info_value);
      return mk(ST_QUEUED, 0, 0, 0);
    end
    for (int i = 0; i < 32; i++)
      if (sh_pend[i] && !q.hold_mask[i]) begin
        sh_pend[i] = 0;
        return mk(ST_FOUND, 7'(i + 1), sh_code[i], sh_value[i]);
      end
    if (t < NTHR)
      for (int k = 0; k < rt_sig[t].size(); k++)
        if (!q.hold_mask[rt_sig[t][k] - 1]) begin
          sig_res_t r;
          r = mk(ST_FOUND, rt_sig[t][k], rt_code[t][k], rt_value[t][k]);
          rt_sig[t].delete(k); rt_code[t].delete(k); rt_value[t].delete(k);
          return r;
        end
    return mk(ST_NONE, 0, 0, 0);
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: actual %0d %0d %h %h", $time, status,
                 out_sig_number, out_code, out_value);
        fails++;
      end else begin
        sig_res_t e;
        e = pending_results.pop_front();
        if (status !== e.status || out_sig_number !== e.sig || out_code !== e.code ||
            out_value !== e.value) begin
          $display("%0t mismatch: expected %0d %0d %h %h actual %0d %0d %h %h", $time,
                   e.status, e.sig, e.code, e.value, status, out_sig_number, out_code,
                   out_value);
          fails++;
        end
      end
    end
  end

  // start stays high between back-to-back requests; it drops only for idle gaps
  task automatic issue(sig_req_t q, bit typed, sig_res_t want);
    sig_res_t p;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    start <= 1; kind <= q.kind; thread <= q.thread; sig_number <= q.sig_number;
    info_code <= q.info_code; info_value <= q.info_value; hold_mask <= q.hold_mask;
    @(posedge clk);
    while (busy) @(posedge clk);
    p = predict_signal(q);
    if (typed && p != want) begin
      $display("%0t predictor disagrees with table: expected %0d %0d actual %0d %0d",
               $time, want.status, want.sig, p.status, p.sig);
      fails++;
    end
    pending_results.push_back(p);
  endtask

  function automatic sig_req_t rq(logic k, logic [3:0] t, logic [6:0] n, logic [31:0] c,
                                  logic [31:0] v, logic [63:0] m);
    sig_req_t q;
    q.kind = k; q.thread = t; q.sig_number = n; q.info_code = c; q.info_value = v;
    q.hold_mask = m;
    return q;
  endfunction

  function automatic sig_req_t rand_req();
    sig_req_t q;
    int r;
    q.kind = $urandom_range(0, 1);
    q.thread = $urandom_range(0, 3) == 0 ? 4'($urandom) : 4'($urandom_range(0, 2));
    r = $urandom_range(0, 19);
    q.sig_number = r == 0 ? 7'($urandom) : r < 8 ? 7'($urandom_range(1, 32))
                                                 : 7'($urandom_range(33, 64));
    q.info_code = $urandom; q.info_value = $urandom;
    r = $urandom_range(0, 3);
    q.hold_mask = r == 0 ? 64'd0 : r == 1 ? {$urandom, $urandom}
                                            : {$urandom, $urandom} & {$urandom, $urandom};
    return q;
  endfunction

  table_row_t dir[$];

  initial begin
    sig_res_t nores;
    nores = mk(ST_NONE, 0, 0, 0);
    rst = 1; start = 0; kind = 0; thread = 0; sig_number = 0; info_code = 0;
    info_value = 0; hold_mask = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    dir.push_back('{rq(KIND_FETCH, 0, 0, 0, 0, 0), 1, nores});
    dir.push_back('{rq(KIND_ENQ, 0, 0, 0, 0, 0), 1, mk(ST_DROPPED, 0, 0, 0)});
    dir.push_back('{rq(KIND_ENQ, 15, 127, '1, '1, '1), 1, mk(ST_DROPPED, 0, 0, 0)});
    dir.push_back('{rq(KIND_ENQ, 15, 65, 0, 0, 0), 1, mk(ST_DROPPED, 0, 0, 0)});
    dir.push_back('{rq(KIND_ENQ, 0, 1, 32'h80000000, 32'hffffffff, 0), 1,
                    mk(ST_QUEUED, 0, 0, 0)});
    dir.push_back('{rq(KIND_ENQ, 3, 1, 5, 6, 0), 1, mk(ST_ALREADY, 0, 0, 0)});
    dir.push_back('{rq(KIND_ENQ, 15, 32, 32'h7fffffff, 0, '1), 1, mk(ST_QUEUED, 0, 0, 0)});
    dir.push_back('{rq(KIND_ENQ, 15, 64, 11, 22, 0), 1, mk(ST_QUEUED, 0, 0, 0)});
    dir.push_back('{rq(KIND_ENQ, 15, 33, 33, 44, 0), 1, mk(ST_QUEUED, 0, 0, 0)});
    dir.push_back('{rq(KIND_FETCH, 15, 0, 0, 0, 64'h1), 1,
                    mk(ST_FOUND, 32, 32'h7fffffff, 0)});
    dir.push_back('{rq(KIND_FETCH, 15, 9, 1, 1, 0), 1,
                    mk(ST_FOUND, 1, 32'h80000000, 32'hffffffff)});
    dir.push_back('{rq(KIND_FETCH, 15, 0, 0, 0, 64'h8000000000000000), 1,
                    mk(ST_FOUND, 33, 33, 44)});
    dir.push_back('{rq(KIND_FETCH, 15, 0, 0, 0, '1), 1, nores});
    dir.push_back('{rq(KIND_FETCH, 15, 0, 0, 0, 0), 1, mk(ST_FOUND, 64, 11, 22)});
    for (int i = 0; i < 17; i++)
      dir.push_back('{rq(KIND_ENQ, 2, 7'(33 + i), i, ~i, 0), 1,
                      mk(i < 16 ? ST_QUEUED : ST_DROPPED, 0, 0, 0)});
    dir.push_back('{rq(KIND_FETCH, 2, 0, 0, 0, {32'h0000_0007, 32'h0}), 0, nores});
    dir.push_back('{rq(KIND_FETCH, 2, 0, 0, 0, 0), 0, nores});

    foreach (dir[i]) issue(dir[i].req, dir[i].typed, dir[i].res);

    for (int i = 0; i < RAND_REQS; i++) begin
      if (i == RAND_REQS / 2) begin
        start <= 0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      if (i > RAND_REQS - 60) quiet = 1;
      issue(rand_req(), 0, nores);
    end
    start <= 0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

[signal_pending_queue_core.f]
sv/spq_pkg.sv
sv/spq_mem.sv
sv/signal_pending_queue_core.sv
tb/sv/tb.sv
